>>> design/serial_rx_event_conditioner_top_defines.svh
// Assertion macros shared by the conditioner RTL.
// Each macro expects clk and rst to exist in the module that uses it.
`ifndef SERIAL_RX_EVENT_CONDITIONER_TOP_DEFINES_SVH
`define SERIAL_RX_EVENT_CONDITIONER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SREC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SREC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/srec_pkg.sv
package srec_pkg;

  typedef enum logic [1:0] {
    REQ_RX_CHAR    = 2'd0,
    REQ_SPECIAL_RX = 2'd1,
    REQ_EXT_STATUS = 2'd2,
    REQ_TX_ACK     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    EV_CHAR   = 3'd0,
    EV_BREAK  = 3'd1,
    EV_WAKE   = 3'd2,
    EV_HANGUP = 3'd3,
    EV_RESUME = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    CFG_STRIP_HIGH_BIT   = 3'd0,
    CFG_IGNORE_BREAK     = 3'd1,
    CFG_BREAK_INTERRUPTS = 3'd2,
    CFG_CHECK_ERROR_BIT  = 3'd3,
    CFG_IGNORE_PARITY    = 3'd4,
    CFG_MARK_ERRORS      = 3'd5,
    CFG_LOCAL_LINE       = 3'd6,
    CFG_PORT_OPEN        = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic strip_high_bit;
    logic ignore_break;
    logic break_interrupts;
    logic check_error_bit;
    logic ignore_parity;
    logic mark_errors;
    logic local_line;
    logic port_open;
  } cfg_t;

  typedef struct packed {
    ev_t        kind;
    logic [7:0] data;
  } res_t;

  // Up to three results per request, r0 goes out first.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } res_list_t;

  localparam logic [7:0] CHAR_7BIT_MASK = 8'h7f;
  localparam logic [7:0] MARK_BYTE      = 8'hff;
  localparam int unsigned ST_BREAK_BIT  = 6;  // status 0x40
  localparam int unsigned ST_PARITY_BIT = 5;  // status 0x20
  localparam int unsigned EXT_BREAK_BIT = 7;  // ext status 0x80
  localparam int unsigned EXT_DCD_BIT   = 3;  // ext status 0x08

endpackage

>>> design/srec_decode.sv
module srec_decode
  import srec_pkg::*;
(
  input  cfg_t       cfg,
  input  logic       carrier_on,
  input  logic [1:0] req_type,
  input  logic [7:0] char_in,
  input  logic [7:0] status_in,
  output res_list_t  res,
  output logic       carrier_next
);

  logic st_err;
  logic st_par;
  logic brk;
  logic wake;
  logic hang;
  res_t second;

  always_comb begin
    res          = '0;
    carrier_next = carrier_on;
    // 0x40 only counts when error checking is enabled
    st_err = status_in[ST_BREAK_BIT] & cfg.check_error_bit;
    st_par = status_in[ST_PARITY_BIT];
    brk    = char_in[EXT_BREAK_BIT] & ~cfg.ignore_break & cfg.break_interrupts;
    wake   = ~cfg.local_line & char_in[EXT_DCD_BIT] & ~carrier_on;
    hang   = ~cfg.local_line & ~char_in[EXT_DCD_BIT] & carrier_on & cfg.port_open;
    second = '{kind: (wake ? EV_WAKE : EV_HANGUP), data: 8'h00};

    case (req_t'(req_type))
      REQ_RX_CHAR: begin
        if (cfg.port_open) begin
          res.cnt = 2'd1;
          res.r0  = '{kind: EV_CHAR,
                      data: (cfg.strip_high_bit ? (char_in & CHAR_7BIT_MASK) : char_in)};
        end
      end
      REQ_SPECIAL_RX: begin
        if (cfg.port_open && (st_err || st_par)) begin
          if (st_err) begin
            if (cfg.ignore_break) begin
              res.cnt = 2'd0;
            end else if (cfg.break_interrupts) begin
              res.cnt = 2'd1;
              res.r0  = '{kind: EV_BREAK, data: 8'h00};
            end else if (cfg.mark_errors) begin
              // marked sequence, char passed unstripped
              res.cnt = 2'd3;
              res.r0  = '{kind: EV_CHAR, data: MARK_BYTE};
              res.r1  = '{kind: EV_CHAR, data: 8'h00};
              res.r2  = '{kind: EV_CHAR, data: char_in};
            end else begin
              res.cnt = 2'd1;
              res.r0  = '{kind: EV_CHAR, data: 8'h00};
            end
          end else if (!cfg.ignore_parity) begin
            res.cnt = 2'd1;
            res.r0  = '{kind: EV_CHAR, data: 8'h00};
          end
        end
      end
      REQ_EXT_STATUS: begin
        if (brk) begin
          res.cnt = 2'd1;
          res.r0  = '{kind: EV_BREAK, data: 8'h00};
        end
        if (wake || hang) begin
          res.cnt = brk ? 2'd2 : 2'd1;
          if (brk) begin
            res.r1 = second;
          end else begin
            res.r0 = second;
          end
        end
        // carrier loss clears state even with the port closed
        if (!cfg.local_line) begin
          carrier_next = char_in[EXT_DCD_BIT];
        end
      end
      REQ_TX_ACK: begin
        res.cnt = 2'd1;
        res.r0  = '{kind: EV_RESUME, data: 8'h00};
      end
      default: begin
        res.cnt = 2'd0;
      end
    endcase
  end

endmodule

>>> design/srec_emit.sv
`include "serial_rx_event_conditioner_top_defines.svh"

module srec_emit
  import srec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_list_t  list,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_kind,
  output logic [7:0] data_out,
  output logic       last
);

  logic [1:0] rem;
  res_t       r0;
  res_t       r1;
  res_t       r2;
  logic       take;

  assign out_valid  = (rem != 2'd0);
  assign last       = (rem == 2'd1);
  assign take       = out_valid & ~out_stall;
  assign can_load   = ~out_valid | (take & last);
  assign event_kind = r0.kind;
  assign data_out   = r0.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= list.cnt;
    end else if (take) begin
      rem <= rem - 2'd1;
    end
  end

  // shift line: head entry always drives the port
  always_ff @(posedge clk) begin
    if (load) begin
      r0 <= list.r0;
      r1 <= list.r1;
      r2 <= list.r2;
    end else if (take) begin
      r0 <= r1;
      r1 <= r2;
    end
  end

  `SREC_ASSERT_NOW(a_load_when_free, load, can_load, "load while results still pending")
  `SREC_ASSERT_NEXT(a_load_shows, load && (list.cnt != 2'd0), out_valid, "loaded results not shown")
  `SREC_ASSERT_NEXT(a_last_drains, take && last && !load, !out_valid, "valid after last result")

endmodule

>>> design/serial_rx_event_conditioner_top.sv
// Serial receive event conditioner.
// Input channel (in_valid / in_stall): one controller request per accepted
// item, carrying req_type, char_in and status_in. Output channel
// (out_valid / out_stall): zero to three result items per request, each with
// event_kind, data_out and last; last marks the final result of a request.
// Config channel (cfg_valid / cfg_ready, always ready): writes one bit of
// cfg_data into register cfg_index; the user must write only while the block
// is idle, which the block itself does not enforce. A request passes through
// the input register, then the three-entry result shift line. Throughput: one
// request per cycle when each gives at most one result and out_stall stays
// low; a request with more results holds the line until its last is taken.
// Requests with no result leave the result line free.
// Stall: while out_stall is high the head result holds; one request can
// wait in the input register, then in_stall rises.
// Reset (rst, synchronous): all config bits and the carrier flag clear, the
// input register and result line empty.
`include "serial_rx_event_conditioner_top_defines.svh"

module serial_rx_event_conditioner_top
  import srec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] char_in,
  input  logic [7:0] status_in,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_kind,
  output logic [7:0] data_out,
  output logic       last,
  // config write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic       cfg_data
);

  cfg_t       cfg;
  logic       carrier_on;
  logic       carrier_next;
  logic       in_vld_q;
  logic [1:0] req_q;
  logic [7:0] char_q;
  logic [7:0] status_q;
  logic       can_load;
  logic       advance;
  logic       accept;
  res_list_t  res;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STRIP_HIGH_BIT:   cfg.strip_high_bit   <= cfg_data;
        CFG_IGNORE_BREAK:     cfg.ignore_break     <= cfg_data;
        CFG_BREAK_INTERRUPTS: cfg.break_interrupts <= cfg_data;
        CFG_CHECK_ERROR_BIT:  cfg.check_error_bit  <= cfg_data;
        CFG_IGNORE_PARITY:    cfg.ignore_parity    <= cfg_data;
        CFG_MARK_ERRORS:      cfg.mark_errors      <= cfg_data;
        CFG_LOCAL_LINE:       cfg.local_line       <= cfg_data;
        CFG_PORT_OPEN:        cfg.port_open        <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // input register: request moves on once the result line can take it
  assign advance  = in_vld_q & can_load;
  assign in_stall = in_vld_q & ~can_load;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q    <= req_type;
      char_q   <= char_in;
      status_q <= status_in;
    end
  end

  // carrier flag commits together with the request's results
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_on <= 1'b0;
    end else if (advance) begin
      carrier_on <= carrier_next;
    end
  end

  srec_decode u_decode (
    .cfg          (cfg),
    .carrier_on   (carrier_on),
    .req_type     (req_q),
    .char_in      (char_q),
    .status_in    (status_q),
    .res          (res),
    .carrier_next (carrier_next)
  );

  srec_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .list       (res),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .data_out   (data_out),
    .last       (last)
  );

  `SREC_ASSERT_NEXT(a_carrier_hold, !advance, $stable(carrier_on), "carrier moved without request")
  `SREC_ASSERT_NEXT(a_empty_req, advance && (res.cnt == 2'd0), !out_valid, "result from empty request")
  `SREC_ASSERT_NOW(a_local_carrier, advance && cfg.local_line, carrier_next == carrier_on, "carrier changed on local line")

endmodule

>>> sim/tb_top.sv
module tb_top;
  import srec_pkg::*;

  // One expected result: what the conditioner should put on the result port.
  typedef struct {
    ev_t        kind;
    logic [7:0] data;
    logic       last;
  } ev_rec_t;

  // Generous cycle budget. The slowest correct run is about 300 requests, each
  // with the longest send gap plus three results that each sit out the longest
  // stall, plus the config writes and drains.
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 4;  // lets requests with no result clear

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] req_type = REQ_RX_CHAR;
  logic [7:0] char_in = 8'h00;
  logic [7:0] status_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] event_kind;
  logic [7:0] data_out;
  logic       last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = CFG_STRIP_HIGH_BIT;
  logic       cfg_data = 1'b0;

  // Shadow of the line settings and the carrier flag, updated as the block's are.
  cfg_t       line_cfg = '0;
  logic       line_carrier = 1'b0;

  // Results still owed by the block, oldest first.
  ev_rec_t    pending_events[$];
  ev_rec_t    staged[$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          burst_mode = 1'b0;  // both sides stop idling while set

  serial_rx_event_conditioner_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .char_in    (char_in),
    .status_in  (status_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .data_out   (data_out),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_events.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void stage(ev_t k, logic [7:0] d);
    staged.push_back('{kind: k, data: d, last: 1'b0});
  endfunction

  // Terminal input rules applied to one request. Queues the results the
  // request should produce and moves the carrier flag along.
  function automatic void condition_request(req_t rq, logic [7:0] ch, logic [7:0] st);
    logic [7:0] s;
    s = st;
    staged.delete();
    case (rq)
      REQ_RX_CHAR: begin
        if (line_cfg.port_open)
          stage(EV_CHAR, line_cfg.strip_high_bit ? (ch & CHAR_7BIT_MASK) : ch);
      end
      REQ_SPECIAL_RX: begin
        if (line_cfg.port_open) begin
          // error bit only counts when checking is enabled
          if (!line_cfg.check_error_bit)
            s[ST_BREAK_BIT] = 1'b0;
          if (s[ST_BREAK_BIT]) begin
            if (line_cfg.ignore_break) begin
              // break dropped entirely
            end else if (line_cfg.break_interrupts) begin
              stage(EV_BREAK, 8'h00);
            end else if (line_cfg.mark_errors) begin
              // marked sequence; the character goes out unstripped
              stage(EV_CHAR, MARK_BYTE);
              stage(EV_CHAR, 8'h00);
              stage(EV_CHAR, ch);
            end else begin
              stage(EV_CHAR, 8'h00);
            end
          end else if (s[ST_PARITY_BIT] && !line_cfg.ignore_parity) begin
            stage(EV_CHAR, 8'h00);
          end
        end
      end
      REQ_EXT_STATUS: begin
        if (ch[EXT_BREAK_BIT] && !line_cfg.ignore_break && line_cfg.break_interrupts)
          stage(EV_BREAK, 8'h00);
        if (!line_cfg.local_line) begin
          if (ch[EXT_DCD_BIT]) begin
            if (!line_carrier) begin
              stage(EV_WAKE, 8'h00);
              line_carrier = 1'b1;
            end
          end else if (line_carrier) begin
            // carrier drop on a closed port clears the flag silently
            if (line_cfg.port_open)
              stage(EV_HANGUP, 8'h00);
            line_carrier = 1'b0;
          end
        end
      end
      default: stage(EV_RESUME, 8'h00);
    endcase
    if (staged.size() != 0)
      staged[staged.size() - 1].last = 1'b1;
    foreach (staged[i])
      pending_events.push_back(staged[i]);
  endfunction

  // Result side: checks every accepted result against the oldest expectation,
  // then draws how long to stall before taking the next one.
  always @(posedge clk) begin : result_check
    ev_rec_t     want;
    int unsigned hold;
    if (rst) begin
      out_stall <= 1'b0;
      hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d data=%02h last=%0b",
                                    event_kind, data_out, last));
        end else begin
          want = pending_events.pop_front();
          if (event_kind !== 3'(want.kind))
            report_mismatch($sformatf("event_kind %0d, expected %0d", event_kind,
                                      want.kind));
          if (data_out !== want.data)
            report_mismatch($sformatf("data_out %02h, expected %02h", data_out,
                                      want.data));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
        end
        hold = burst_mode ? 0 : $urandom_range(0, 8);
        out_stall <= (hold != 0);
      end else if (hold != 0) begin
        hold = hold - 1;
        out_stall <= (hold != 0);
      end
    end
  end

  // Sends one request after a random gap. in_valid stays high on return so a
  // back-to-back request never lowers and raises it in the same step.
  task automatic send_req(req_t rq, logic [7:0] ch, logic [7:0] st);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rq;
    char_in   <= ch;
    status_in <= st;
    do @(posedge clk); while (in_stall);
    condition_request(rq, ch, st);
  endtask

  // Stops sending and waits for every owed result, then waits out DRAIN_CYCLES
  // for requests that produce nothing.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STRIP_HIGH_BIT:   line_cfg.strip_high_bit   = v;
      CFG_IGNORE_BREAK:     line_cfg.ignore_break     = v;
      CFG_BREAK_INTERRUPTS: line_cfg.break_interrupts = v;
      CFG_CHECK_ERROR_BIT:  line_cfg.check_error_bit  = v;
      CFG_IGNORE_PARITY:    line_cfg.ignore_parity    = v;
      CFG_MARK_ERRORS:      line_cfg.mark_errors      = v;
      CFG_LOCAL_LINE:       line_cfg.local_line       = v;
      default:              line_cfg.port_open        = v;
    endcase
  endtask

  // Rewrites every register; only done with the block drained.
  task automatic set_config(cfg_t c);
    quiesce();
    write_reg(CFG_STRIP_HIGH_BIT,   c.strip_high_bit);
    write_reg(CFG_IGNORE_BREAK,     c.ignore_break);
    write_reg(CFG_BREAK_INTERRUPTS, c.break_interrupts);
    write_reg(CFG_CHECK_ERROR_BIT,  c.check_error_bit);
    write_reg(CFG_IGNORE_PARITY,    c.ignore_parity);
    write_reg(CFG_MARK_ERRORS,      c.mark_errors);
    write_reg(CFG_LOCAL_LINE,       c.local_line);
    write_reg(CFG_PORT_OPEN,        c.port_open);
    cfg_valid <= 1'b0;
  endtask

  // Reset settings: port closed, so only status changes and acks get through.
  // A carrier drop here clears the flag without a hangup.
  task automatic test_closed_port();
    send_req(REQ_RX_CHAR,    8'hff, 8'h00);
    send_req(REQ_SPECIAL_RX, 8'h55, 8'h60);
    send_req(REQ_EXT_STATUS, 8'h08, 8'h00);  // carrier up -> wake
    send_req(REQ_EXT_STATUS, 8'h00, 8'h00);  // carrier down, silent
    send_req(REQ_TX_ACK,     8'h00, 8'hff);
  endtask

  task automatic test_rx_chars();
    cfg_t c;
    c = '0;
    c.port_open = 1'b1;
    set_config(c);
    send_req(REQ_RX_CHAR, 8'h00, 8'hff);
    send_req(REQ_RX_CHAR, 8'hff, 8'h00);
    c.strip_high_bit = 1'b1;
    set_config(c);
    send_req(REQ_RX_CHAR, 8'hff, 8'h00);
    send_req(REQ_RX_CHAR, 8'h80, 8'h00);
  endtask

  task automatic test_special_rx();
    cfg_t c;
    c = '0;
    c.port_open = 1'b1;
    set_config(c);
    send_req(REQ_SPECIAL_RX, 8'h12, 8'h40);  // error bit masked off -> nothing
    send_req(REQ_SPECIAL_RX, 8'h12, 8'h00);  // no error bits -> nothing
    send_req(REQ_SPECIAL_RX, 8'h34, 8'h9f);  // 0x40 and 0x20 both clear -> nothing
    c.check_error_bit = 1'b1;
    set_config(c);
    send_req(REQ_SPECIAL_RX, 8'h56, 8'h40);  // error bit, no mark -> null char
    c.mark_errors    = 1'b1;
    c.strip_high_bit = 1'b1;
    set_config(c);
    send_req(REQ_SPECIAL_RX, 8'ha5, 8'hc0);  // marked sequence, char unstripped
    send_req(REQ_SPECIAL_RX, 8'ha5, 8'h20);  // parity ignores mark
    c.break_interrupts = 1'b1;
    set_config(c);
    send_req(REQ_SPECIAL_RX, 8'h77, 8'h60);  // break event
    c.ignore_break  = 1'b1;
    c.ignore_parity = 1'b1;
    set_config(c);
    send_req(REQ_SPECIAL_RX, 8'h77, 8'h40);
    send_req(REQ_SPECIAL_RX, 8'h77, 8'h20);
  endtask

  task automatic test_ext_status();
    cfg_t c;
    c = '0;
    c.port_open        = 1'b1;
    c.break_interrupts = 1'b1;
    set_config(c);
    send_req(REQ_EXT_STATUS, 8'h88, 8'h00);  // break then wake
    send_req(REQ_EXT_STATUS, 8'h80, 8'h00);  // break then hangup
    send_req(REQ_EXT_STATUS, 8'h08, 8'h00);  // wake
    c.local_line = 1'b1;
    set_config(c);
    send_req(REQ_EXT_STATUS, 8'h00, 8'h00);  // carrier ignored, stays up
    c.local_line   = 1'b0;
    c.ignore_break = 1'b1;
    set_config(c);
    send_req(REQ_EXT_STATUS, 8'hf7, 8'hff);  // break dropped, hangup
  endtask

  task automatic send_random();
    int unsigned pick;
    req_t        rq;
    logic [7:0]  st;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      rq = REQ_RX_CHAR;
    else if (pick < 65)
      rq = REQ_SPECIAL_RX;
    else if (pick < 90)
      rq = REQ_EXT_STATUS;
    else
      rq = REQ_TX_ACK;
    st = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0)
      st = st & ~8'h60;
    send_req(rq, 8'($urandom_range(0, 255)), st);
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) send_random();
  endtask

  // Random traffic over several line settings, the all-clear and all-set
  // extremes first. One stretch runs with no idling on either side, and one
  // phase pauses mid-stream until every owed result has come back.
  task automatic test_random_settings();
    cfg_t c;
    c = '0;
    set_config(c);
    run_random(20);
    c = '1;
    set_config(c);
    run_random(30);
    for (int p = 0; p < 5; p++) begin
      c = cfg_t'(8'($urandom_range(0, 255)));
      c.port_open = ($urandom_range(0, 4) != 0);
      set_config(c);
      if (p == 1)
        burst_mode = 1'b1;
      run_random(20);
      burst_mode = 1'b0;
      if (p == 2)
        quiesce();
      run_random(20);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_closed_port();
    test_rx_chars();
    test_special_rx();
    test_ext_status();
    test_random_settings();
    quiesce();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
